@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ src/tisd_pkg.sv @@
`default_nettype none
package tisd_pkg;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_EXT_TAG,
      PH_LEN_SEL,
      PH_LEN_MORE,
      PH_CONTENT
   } phase_type;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_OPEN  = 2'd1;
   localparam logic [1:0] KIND_CLOSE = 2'd2;

   localparam logic [3:0] TAG_EXT_NIBBLE = 4'hF;
   localparam logic [2:0] LVT_EXT        = 3'd5;
   localparam logic [2:0] LVT_OPEN       = 3'd6;
   localparam logic [2:0] LVT_CLOSE      = 3'd7;
   localparam logic [7:0] LEN_SEL_16     = 8'd254;
   localparam logic [7:0] LEN_SEL_32     = 8'd255;

   typedef struct packed {
      logic [7:0]  tag_id;
      logic        is_context;
      logic [1:0]  item_kind;
      logic [31:0] content_length;
      logic [31:0] unsigned_value;
      logic [2:0]  header_bytes;
   } rsp_payload_type;

   typedef struct packed {
      logic            emit;
      rsp_payload_type payload;
   } parse_result_type;

endpackage
`default_nettype wire

@@ src/tisd_if.sv @@
`default_nettype none
interface tisd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       restart;

   modport source (output valid, output data_byte, output restart, input ready);
   modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface tisd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  tag_id;
   logic        is_context;
   logic [1:0]  item_kind;
   logic [31:0] content_length;
   logic [31:0] unsigned_value;
   logic [2:0]  header_bytes;

   modport source (output valid, output tag_id, output is_context, output item_kind,
                   output content_length, output unsigned_value, output header_bytes,
                   input ready);
   modport sink   (input valid, input tag_id, input is_context, input item_kind,
                   input content_length, input unsigned_value, input header_bytes,
                   output ready);
endinterface
`default_nettype wire

@@ src/tisd_parser.sv @@
`default_nettype none
module tisd_parser
   import tisd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [7:0]       data_byte,
   input  wire logic             restart,
   output parse_result_type      result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  tag_ff, tag_in;
   logic        class_ff, class_in;
   logic [31:0] len_ff, len_in;
   logic [2:0]  ext_left_ff, ext_left_in;
   logic [31:0] content_left_ff, content_left_in;
   logic [31:0] value_ff, value_in;
   logic [2:0]  hdr_count_ff, hdr_count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         tag_ff          <= '0;
         class_ff        <= 1'b0;
         len_ff          <= '0;
         ext_left_ff     <= '0;
         content_left_ff <= '0;
         value_ff        <= '0;
         hdr_count_ff    <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         tag_ff          <= tag_in;
         class_ff        <= class_in;
         len_ff          <= len_in;
         ext_left_ff     <= ext_left_in;
         content_left_ff <= content_left_in;
         value_ff        <= value_in;
         hdr_count_ff    <= hdr_count_in;
      end
   end

   always_comb begin
      phase_type   cur;
      logic        do_tag;
      logic        do_len;
      logic [2:0]  lvt;
      logic [2:0]  ext_dec;
      logic [31:0] cl_dec;
      logic        short_len;

      cur             = restart ? PH_HEADER : phase_ff;
      phase_in        = cur;
      tag_in          = tag_ff;
      class_in        = class_ff;
      len_in          = len_ff;
      ext_left_in     = ext_left_ff;
      content_left_in = content_left_ff;
      value_in        = value_ff;
      hdr_count_in    = hdr_count_ff;
      do_tag          = 1'b0;
      do_len          = 1'b0;
      lvt             = len_ff[2:0];
      ext_dec         = ext_left_ff - 3'd1;
      cl_dec          = content_left_ff - 32'd1;
      short_len       = (len_ff >= 32'd1) && (len_ff <= 32'd4);
      result          = '0;

      unique case (cur)
         PH_HEADER: begin
            class_in        = data_byte[3];
            tag_in          = {4'd0, data_byte[7:4]};
            len_in          = {29'd0, data_byte[2:0]};
            lvt             = data_byte[2:0];
            hdr_count_in    = 3'd1;
            ext_left_in     = '0;
            content_left_in = '0;
            value_in        = '0;
            if (data_byte[7:4] == TAG_EXT_NIBBLE) phase_in = PH_EXT_TAG;
            else do_tag = 1'b1;
         end
         PH_EXT_TAG: begin
            tag_in       = data_byte;
            hdr_count_in = hdr_count_ff + 3'd1;
            do_tag       = 1'b1;
         end
         PH_LEN_SEL: begin
            hdr_count_in = hdr_count_ff + 3'd1;
            if (data_byte < LEN_SEL_16) begin
               len_in = {24'd0, data_byte};
               do_len = 1'b1;
            end else begin
               ext_left_in = (data_byte == LEN_SEL_32) ? 3'd4 : 3'd2;
               len_in      = '0;
               phase_in    = PH_LEN_MORE;
            end
         end
         PH_LEN_MORE: begin
            hdr_count_in = hdr_count_ff + 3'd1;
            len_in       = {len_ff[23:0], data_byte};
            ext_left_in  = ext_dec;
            if (ext_dec == 3'd0) do_len = 1'b1;
         end
         PH_CONTENT: begin
            if (short_len) value_in = {value_ff[23:0], data_byte};
            content_left_in = cl_dec;
            if (cl_dec == 32'd0) begin
               result.emit                   = 1'b1;
               result.payload.item_kind      = KIND_DATA;
               result.payload.content_length = len_ff;
               result.payload.unsigned_value = short_len ? value_in : 32'd0;
               phase_in                      = PH_HEADER;
            end
         end
         default: phase_in = PH_HEADER;
      endcase

      // tag known: opening/closing tags finish here, field 5 reads an extension
      if (do_tag) begin
         if (class_in && (lvt == LVT_OPEN)) begin
            result.emit                   = 1'b1;
            result.payload.item_kind      = KIND_OPEN;
            result.payload.content_length = 32'd6;
            phase_in                      = PH_HEADER;
         end else if (class_in && (lvt == LVT_CLOSE)) begin
            result.emit                   = 1'b1;
            result.payload.item_kind      = KIND_CLOSE;
            result.payload.content_length = 32'd7;
            phase_in                      = PH_HEADER;
         end else if (lvt == LVT_EXT) begin
            phase_in = PH_LEN_SEL;
         end else begin
            len_in = {29'd0, lvt};
            do_len = 1'b1;
         end
      end

      // length known: zero length finishes on the header
      if (do_len) begin
         if (len_in == 32'd0) begin
            result.emit                   = 1'b1;
            result.payload.item_kind      = KIND_DATA;
            result.payload.content_length = 32'd0;
            phase_in                      = PH_HEADER;
         end else begin
            content_left_in = len_in;
            value_in        = '0;
            phase_in        = PH_CONTENT;
         end
      end

      result.payload.tag_id       = tag_in;
      result.payload.is_context   = class_in;
      result.payload.header_bytes = hdr_count_in;
   end

endmodule
`default_nettype wire

@@ src/tagged_item_stream_decoder_top.sv @@
// Tagged item stream decoder: takes one byte of a tagged stream per transfer on
// req_if and gives one result on rsp_if for each completed tag (data item,
// opening or closing tag). A byte is accepted every cycle while the result
// side keeps up; a result is shown on rsp_if once its last byte has landed
// in the input register and the single parse step has run into the result
// register; that step waits while a shown result is not taken on rsp_if.
// restart forces the byte to be read as a new header and drops any partial
// item. No configuration; the parser returns to header state on reset.
`default_nettype none
module tagged_item_stream_decoder_top
   import tisd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   tisd_req_if.sink   req_if,
   tisd_rsp_if.source rsp_if
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            in_restart_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff;
   logic            advance;
   logic            step;
   logic            req_take;
   parse_result_type result;

   assign advance      = !out_valid_ff || rsp_if.ready;
   assign step         = in_valid_ff && advance;
   assign req_if.ready = !in_valid_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;

   assign in_valid_in  = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? (step && result.emit) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff    <= req_if.data_byte;
         in_restart_ff <= req_if.restart;
      end
      if (step && result.emit) out_ff <= result.payload;
   end

   tisd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .restart   (in_restart_ff),
      .result    (result)
   );

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.tag_id         = out_ff.tag_id;
   assign rsp_if.is_context     = out_ff.is_context;
   assign rsp_if.item_kind      = out_ff.item_kind;
   assign rsp_if.content_length = out_ff.content_length;
   assign rsp_if.unsigned_value = out_ff.unsigned_value;
   assign rsp_if.header_bytes   = out_ff.header_bytes;

endmodule
`default_nettype wire

@@ src/tisd_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module tisd_checker
   import tisd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_tag_id,
   input wire logic        rsp_is_context,
   input wire logic [1:0]  rsp_item_kind,
   input wire logic [31:0] rsp_content_length,
   input wire logic [31:0] rsp_unsigned_value,
   input wire logic [2:0]  rsp_header_bytes
);

   logic [77:0] rsp_bits;
   logic        kind_ok;
   logic        open_ok;
   logic        close_ok;
   logic        short_len;

   assign rsp_bits  = {rsp_tag_id, rsp_is_context, rsp_item_kind, rsp_content_length,
                       rsp_unsigned_value, rsp_header_bytes};
   assign kind_ok   = (rsp_item_kind == KIND_DATA) || (rsp_item_kind == KIND_OPEN) ||
                      (rsp_item_kind == KIND_CLOSE);
   assign open_ok   = rsp_is_context && (rsp_content_length == 32'(LVT_OPEN)) &&
                      (rsp_unsigned_value == 32'd0);
   assign close_ok  = rsp_is_context && (rsp_content_length == 32'(LVT_CLOSE)) &&
                      (rsp_unsigned_value == 32'd0);
   assign short_len = (rsp_content_length >= 32'd1) && (rsp_content_length <= 32'd4);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bits))
   `ASSERT_IMPLY(a_kind_legal, clock, reset, rsp_valid, kind_ok && (rsp_header_bytes != 3'd0))
   `ASSERT_IMPLY(a_open_form, clock, reset, rsp_valid && (rsp_item_kind == KIND_OPEN), open_ok)
   `ASSERT_IMPLY(a_close_form, clock, reset, rsp_valid && (rsp_item_kind == KIND_CLOSE), close_ok)
   `ASSERT_IMPLY(a_value_len, clock, reset, rsp_valid && (rsp_unsigned_value != 32'd0), short_len)

endmodule

bind tagged_item_stream_decoder_top tisd_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_tag_id         (rsp_if.tag_id),
   .rsp_is_context     (rsp_if.is_context),
   .rsp_item_kind      (rsp_if.item_kind),
   .rsp_content_length (rsp_if.content_length),
   .rsp_unsigned_value (rsp_if.unsigned_value),
   .rsp_header_bytes   (rsp_if.header_bytes)
);
`default_nettype wire
